// ===== hdl/vms_pkg.sv =====
// types, codes and constants shared by the vehicle mode supervisor
package vms_pkg;

  localparam int unsigned MV_W   = 15;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [TIME_W-1:0] HIB_DWELL_MS   = 32'd600000;
  localparam logic [TIME_W-1:0] TRIP_END_MS    = 32'd120000;
  localparam logic [TIME_W-1:0] TRIP_START_MS  = 32'd5000;
  localparam logic [TIME_W-1:0] MOVED_STILL_MS = 32'd300000;
  localparam logic [MV_W:0]     WARN_HYST_MV   = 16'd200;

  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_ON  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_OFF = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WAKE      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HIBERNATE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WARN      = 3'd4;

  localparam logic [MV_W-1:0] RST_DRIVE_ON  = 15'd13200;
  localparam logic [MV_W-1:0] RST_DRIVE_OFF = 15'd12800;
  localparam logic [MV_W-1:0] RST_WAKE      = 15'd12400;
  localparam logic [MV_W-1:0] RST_HIBERNATE = 15'd11600;
  localparam logic [MV_W-1:0] RST_WARN      = 15'd11900;

  typedef enum logic [1:0] {
    VEH_PARKED    = 2'd0,
    VEH_MOVED     = 2'd1,
    VEH_DRIVING   = 2'd2,
    VEH_HIBERNATE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_WAKEUP       = 3'd1,
    EV_HIBERNATE    = 3'd2,
    EV_TRIP_START   = 3'd3,
    EV_TRIP_END     = 3'd4,
    EV_MOTION_ALARM = 3'd5
  } mode_event_t;

  typedef struct packed {
    logic [MV_W-1:0] drive_on_mv;
    logic [MV_W-1:0] drive_off_mv;
    logic [MV_W-1:0] wake_mv;
    logic [MV_W-1:0] hibernate_mv;
    logic [MV_W-1:0] warn_mv;
  } cfg_regs_t;

  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] mode_entry_time;
    logic [TIME_W-1:0] low_volt_start;
    logic              low_volt_valid;
    logic [TIME_W-1:0] drive_hint_start;
    logic              drive_hint_valid;
    logic              warned;
  } sup_state_t;

endpackage

// ===== hdl/vehicle_mode_supervisor_core.sv =====
// vehicle mode supervisor top level: input stage, state, result stage
// an accepted input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while out_tready does not stall, set by the combinational state update
// between the input register and the result register
// reset: mode parked, timers invalid, warning cleared, thresholds at defaults
module vehicle_mode_supervisor_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [47:0]                        in_tdata,  // vbat_mv[14:0], moving[15], now_ms[47:16]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata, // mode[1:0], mode_event[4:2], battery_low_event[5], zero[7:6]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vms_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vms_pkg::MV_W-1:0]           cfg_data
);
  import vms_pkg::*;

  cfg_regs_t         cfg;
  logic              in_valid_r;
  logic [MV_W-1:0]   in_vbat_r;
  logic              in_moving_r;
  logic [TIME_W-1:0] in_now_r;
  sup_state_t        st_r;
  sup_state_t        st_nxt;
  mode_event_t       step_event;
  logic              step_low;
  logic              out_valid_r;
  mode_t             out_mode_r;
  mode_event_t       out_event_r;
  logic              out_low_r;
  logic              out_free;
  logic              advance;

  assign cfg_ready = 1'b1;

  vms_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_addr (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_vbat_r   <= in_tdata[14:0];
      in_moving_r <= in_tdata[15];
      in_now_r    <= in_tdata[47:16];
    end
  end

  vms_step_logic u_step (
    .st                (st_r),
    .cfg               (cfg),
    .vbat_mv           (in_vbat_r),
    .moving            (in_moving_r),
    .now_ms            (in_now_r),
    .st_nxt            (st_nxt),
    .mode_event        (step_event),
    .battery_low_event (step_low)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode             <= VEH_PARKED;
      st_r.mode_entry_time  <= '0;
      st_r.low_volt_start   <= '0;
      st_r.low_volt_valid   <= 1'b0;
      st_r.drive_hint_start <= '0;
      st_r.drive_hint_valid <= 1'b0;
      st_r.warned           <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r  <= st_nxt.mode;
      out_event_r <= step_event;
      out_low_r   <= step_low;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_low_r, out_event_r, out_mode_r};

  a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after a step");

  a_mode_matches : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> st_r.mode == out_mode_r)
    else $error("reported mode differs from held mode");

  a_alarm_moved : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_MOTION_ALARM |-> out_mode_r == VEH_MOVED)
    else $error("motion alarm without moved mode");

  a_wake_parked : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r == EV_WAKEUP || out_event_r == EV_TRIP_END)
    |-> out_mode_r == VEH_PARKED)
    else $error("wakeup or trip end without parked mode");

endmodule

// ===== hdl/vms_cfg_regs.sv =====
// threshold register file written through the configuration channel
module vms_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [vms_pkg::CFG_ADDR_W-1:0]    wr_addr,
  input  logic [vms_pkg::MV_W-1:0]          wr_data,
  output vms_pkg::cfg_regs_t                cfg
);
  import vms_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_addr)
        REG_DRIVE_ON:  cfg_nxt.drive_on_mv  = wr_data;
        REG_DRIVE_OFF: cfg_nxt.drive_off_mv = wr_data;
        REG_WAKE:      cfg_nxt.wake_mv      = wr_data;
        REG_HIBERNATE: cfg_nxt.hibernate_mv = wr_data;
        REG_WARN:      cfg_nxt.warn_mv      = wr_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_on_mv  <= RST_DRIVE_ON;
      cfg_r.drive_off_mv <= RST_DRIVE_OFF;
      cfg_r.wake_mv      <= RST_WAKE;
      cfg_r.hibernate_mv <= RST_HIBERNATE;
      cfg_r.warn_mv      <= RST_WARN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/vms_step_logic.sv =====
// per-tick mode, timer and warning update with event decode
module vms_step_logic (
  input  vms_pkg::sup_state_t           st,
  input  vms_pkg::cfg_regs_t            cfg,
  input  logic [vms_pkg::MV_W-1:0]      vbat_mv,
  input  logic                          moving,
  input  logic [vms_pkg::TIME_W-1:0]    now_ms,
  output vms_pkg::sup_state_t           st_nxt,
  output vms_pkg::mode_event_t          mode_event,
  output logic                          battery_low_event
);
  import vms_pkg::*;

  // next state
  always_comb begin
    logic [TIME_W-1:0] lv_start;
    logic [TIME_W-1:0] dh_start;
    logic [TIME_W-1:0] lv_elapsed;
    logic [TIME_W-1:0] dh_elapsed;
    logic [TIME_W-1:0] mode_elapsed;
    logic              hib_entered;

    st_nxt       = st;
    lv_start     = st.low_volt_valid ? st.low_volt_start : now_ms;
    dh_start     = st.drive_hint_valid ? st.drive_hint_start : now_ms;
    lv_elapsed   = now_ms - lv_start;
    dh_elapsed   = now_ms - dh_start;
    mode_elapsed = now_ms - st.mode_entry_time;
    hib_entered  = 1'b0;

    if (st.mode == VEH_HIBERNATE) begin
      if (vbat_mv >= cfg.wake_mv) begin
        st_nxt.mode            = VEH_PARKED;
        st_nxt.mode_entry_time = now_ms;
      end
    end else begin
      if (vbat_mv <= cfg.hibernate_mv) begin
        st_nxt.low_volt_start = lv_start;
        st_nxt.low_volt_valid = 1'b1;
        if (lv_elapsed > HIB_DWELL_MS) begin
          st_nxt.mode            = VEH_HIBERNATE;
          st_nxt.mode_entry_time = now_ms;
          hib_entered            = 1'b1;
        end
      end else begin
        st_nxt.low_volt_start = '0;
        st_nxt.low_volt_valid = 1'b0;
      end

      if (!hib_entered) begin
        // low battery warning with hysteresis
        if (vbat_mv <= cfg.warn_mv && !st.warned) begin
          st_nxt.warned = 1'b1;
        end else if ({1'b0, vbat_mv} > ({1'b0, cfg.warn_mv} + WARN_HYST_MV)) begin
          st_nxt.warned = 1'b0;
        end

        if (st.mode == VEH_DRIVING) begin
          if (vbat_mv < cfg.drive_off_mv && !moving) begin
            st_nxt.drive_hint_start = dh_start;
            st_nxt.drive_hint_valid = 1'b1;
            if (dh_elapsed > TRIP_END_MS) begin
              st_nxt.drive_hint_start = '0;
              st_nxt.drive_hint_valid = 1'b0;
              st_nxt.mode             = VEH_PARKED;
              st_nxt.mode_entry_time  = now_ms;
            end
          end else begin
            st_nxt.drive_hint_start = '0;
            st_nxt.drive_hint_valid = 1'b0;
          end
        end else if (vbat_mv >= cfg.drive_on_mv) begin
          st_nxt.drive_hint_start = dh_start;
          st_nxt.drive_hint_valid = 1'b1;
          if (dh_elapsed > TRIP_START_MS) begin
            st_nxt.drive_hint_start = '0;
            st_nxt.drive_hint_valid = 1'b0;
            st_nxt.mode             = VEH_DRIVING;
            st_nxt.mode_entry_time  = now_ms;
          end
        end else begin
          st_nxt.drive_hint_start = '0;
          st_nxt.drive_hint_valid = 1'b0;
          if (moving && st.mode == VEH_PARKED) begin
            st_nxt.mode            = VEH_MOVED;
            st_nxt.mode_entry_time = now_ms;
          end else if (!moving && st.mode == VEH_MOVED &&
                       mode_elapsed > MOVED_STILL_MS) begin
            st_nxt.mode            = VEH_PARKED;
            st_nxt.mode_entry_time = now_ms;
          end
        end
      end
    end
  end

  // mode events follow from the mode transition, the battery low event from a rising warning flag
  always_comb begin
    mode_event = EV_NONE;
    case (st_nxt.mode)
      VEH_PARKED: begin
        if (st.mode == VEH_HIBERNATE) mode_event = EV_WAKEUP;
        else if (st.mode == VEH_DRIVING) mode_event = EV_TRIP_END;
      end
      VEH_MOVED: begin
        if (st.mode == VEH_PARKED) mode_event = EV_MOTION_ALARM;
      end
      VEH_DRIVING: begin
        if (st.mode != VEH_DRIVING) mode_event = EV_TRIP_START;
      end
      VEH_HIBERNATE: begin
        if (st.mode != VEH_HIBERNATE) mode_event = EV_HIBERNATE;
      end
      default: mode_event = EV_NONE;
    endcase
    battery_low_event = st_nxt.warned & ~st.warned;
  end

endmodule
